// ===== rtl/core/pfl_pkg.sv =====
// Shared types and constants of the per-source flood limiter.
`default_nettype none

package pfl_pkg;

  // Number of session slots in the ring of cells.
  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam int TAG_W  = 16;
  localparam int TIME_W = 32;
  localparam int CNT_W  = 8;
  localparam int CFG_W  = 16;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH = 2'd0,
    CFG_RATE_LIMIT    = 2'd1,
    CFG_IDLE_TIMEOUT  = 2'd2,
    CFG_RELEASE_DELAY = 2'd3
  } cfg_idx_t;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_ACCEPTED   = 3'd0,
    KIND_IGNORED    = 3'd1,
    KIND_FLOODING   = 3'd2,
    KIND_RELEASED   = 3'd3,
    KIND_SCAN_DONE  = 3'd4,
    KIND_TABLE_FULL = 3'd5
  } kind_t;

  // Request modes.
  typedef enum logic {
    MODE_MESSAGE = 1'b0,
    MODE_SCAN    = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // One session.
  typedef struct packed {
    logic              valid;
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] last_seen;
    logic [TIME_W-1:0] window_start;
    logic [CNT_W-1:0]  count;
    logic              flooding;
  } entry_t;

  // Ring control from the sequencer.
  typedef struct packed {
    logic             shift;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
  } ring_ctl_t;

  // Per-cell control.
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/per_source_flood_limiter_core.sv =====
// Top level of the per-source flood limiter: a ring of session cells and its sequencer.
//
// Requests enter on the slave stream: s_tuser selects a message (0) or a
// cleanup scan (1); s_tdata carries the source tag and the current time.
// Results leave on the master stream: m_tuser is the verdict, m_tdata the
// source tag and m_tlast marks the final result of a request.
// Sessions sit in a ring of TABLE_ENTRIES cells that rotates once per
// request, so the sequencer sees every entry at the head of the ring in
// ascending index order and returns it, possibly changed, to the tail.
// A message is looked up against every entry as the ring rotates; then the
// session is written, unless the table is full, and its single result is
// emitted. A scan visits every entry in one rotation and then emits the
// final scan-done result. One request is handled at a time and s_tready is
// high only between requests. When the receiver stalls, the result register
// holds and the ring stops at the entry whose result is waiting. Synchronous
// reset clears every session and loads the default configuration.
// Configuration writes through cfg_we, cfg_idx and cfg_data take effect at
// the next clock edge.
`default_nettype none

module per_source_flood_limiter_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [47:0]                   s_tdata,   // source_tag[15:0], now[47:16]
  input  logic                          s_tuser,   // mode[0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [15:0]                   m_tdata,   // result_tag[15:0]
  output logic [2:0]                    m_tuser,   // kind[2:0]
  output logic                          m_tlast,
  input  logic                          cfg_we,
  input  logic [pfl_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [pfl_pkg::CFG_W-1:0]     cfg_data
);
  import pfl_pkg::*;

  entry_t    cells_q [TABLE_ENTRIES];
  entry_t    tail;
  entry_t    wr_ent;
  ring_ctl_t ring;

  pfl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .head     (cells_q[0]),
    .tail     (tail),
    .wr_ent   (wr_ent),
    .ring     (ring)
  );

  // Cell k takes its neighbor's entry on a shift; the last cell takes the
  // processed head entry, closing the ring.
  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
    cell_ctl_t ctl;
    entry_t    nxt;

    assign ctl.shift = ring.shift;
    assign ctl.load  = ring.wr_en && (ring.wr_idx == IDX_W'(k));
    if (k == TABLE_ENTRIES - 1) begin : g_tail
      assign nxt = tail;
    end else begin : g_mid
      assign nxt = cells_q[k + 1];
    end

    pfl_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .shift_in (nxt),
      .wr_ent   (wr_ent),
      .ent      (cells_q[k])
    );
  end

endmodule

`default_nettype wire

// ===== rtl/core/pfl_cell.sv =====
// One session cell of the ring: holds an entry and passes it to its neighbor.
`default_nettype none

module pfl_cell (
  input  logic              clk,
  input  logic              rst,
  input  pfl_pkg::cell_ctl_t ctl,
  input  pfl_pkg::entry_t   shift_in,
  input  pfl_pkg::entry_t   wr_ent,
  output pfl_pkg::entry_t   ent
);
  import pfl_pkg::*;

  // Only the valid bit is cleared; the other fields are written on creation.
  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else if (ctl.load) begin
      ent <= wr_ent;
    end else if (ctl.shift) begin
      ent <= shift_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pfl_ctrl.sv =====
// Sequencer and head-of-ring processing unit of the flood limiter.
`default_nettype none

module pfl_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [47:0]                     s_tdata,
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [15:0]                     m_tdata,
  output logic [2:0]                      m_tuser,
  output logic                            m_tlast,
  input  logic                            cfg_we,
  input  logic [pfl_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [pfl_pkg::CFG_W-1:0]       cfg_data,
  input  pfl_pkg::entry_t                 head,
  output pfl_pkg::entry_t                 tail,
  output pfl_pkg::entry_t                 wr_ent,
  output pfl_pkg::ring_ctl_t              ring
);
  import pfl_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  state_t state, state_next;

  logic [15:0]       window_length;
  logic [CNT_W-1:0]  rate_limit;
  logic [15:0]       idle_timeout;
  logic [15:0]       release_delay;

  logic              mode_r;
  logic [TAG_W-1:0]  tag_r;
  logic [TIME_W-1:0] now_r;
  logic [IDX_W-1:0]  cnt;

  logic              hit_found, free_found;
  logic [IDX_W-1:0]  hit_idx, free_idx;
  entry_t            hit_ent;

  logic              can_emit;
  logic              accept;
  logic              advance;
  logic              emit;
  kind_t             emit_kind;
  logic [TAG_W-1:0]  emit_tag;
  logic              emit_last;

  // Scan decisions for the entry at the head.
  logic              scan_idle, scan_rel, scan_emit;
  entry_t            scan_ent;

  // Message update for the session found or created.
  entry_t            base, upd;
  logic [CNT_W-1:0]  cnt_inc;
  logic              in_win;
  kind_t             msg_kind;

  assign can_emit = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    scan_idle = (now_r - head.last_seen) > {16'd0, idle_timeout};
    scan_rel  = head.flooding && ((now_r - head.window_start) > {16'd0, release_delay});
    scan_ent  = head;
    scan_emit = 1'b0;
    if (head.valid) begin
      if (scan_idle) begin
        scan_ent.valid = 1'b0;
      end else if (scan_rel) begin
        scan_ent.flooding = 1'b0;
        scan_ent.count    = '0;
        scan_emit         = 1'b1;
      end
    end
  end

  always_comb begin
    if (hit_found) begin
      base = hit_ent;
    end else begin
      base.valid        = 1'b1;
      base.tag          = tag_r;
      base.last_seen    = now_r;
      base.window_start = now_r;
      base.count        = CNT_W'(1);
      base.flooding     = 1'b0;
    end
    cnt_inc = (base.count == '1) ? base.count : base.count + CNT_W'(1);
    in_win  = (now_r - base.window_start) <= {16'd0, window_length};
    upd           = base;
    upd.last_seen = now_r;
    if (!hit_found && !free_found) begin
      msg_kind = KIND_TABLE_FULL;
    end else if (base.flooding) begin
      msg_kind = KIND_IGNORED;
    end else if (in_win) begin
      upd.count = cnt_inc;
      if (cnt_inc >= rate_limit) begin
        upd.flooding = 1'b1;
        msg_kind     = KIND_FLOODING;
      end else begin
        msg_kind     = KIND_ACCEPTED;
      end
    end else begin
      upd.window_start = now_r;
      upd.count        = CNT_W'(1);
      upd.flooding     = 1'b0;
      msg_kind         = KIND_ACCEPTED;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (s_tuser == MODE_SCAN) ? ST_SCAN : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (cnt == LAST_IDX) state_next = ST_UPDATE;
      end
      ST_SCAN: begin
        if (advance && cnt == LAST_IDX) state_next = ST_DONE;
      end
      ST_UPDATE, ST_DONE: begin
        if (can_emit) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    advance     = 1'b0;
    emit        = 1'b0;
    emit_kind   = KIND_ACCEPTED;
    emit_tag    = tag_r;
    emit_last   = 1'b1;
    tail        = head;
    ring.shift  = 1'b0;
    ring.wr_en  = 1'b0;
    ring.wr_idx = hit_found ? hit_idx : free_idx;
    wr_ent      = upd;
    unique case (state)
      ST_SEARCH: begin
        advance    = 1'b1;
        ring.shift = 1'b1;
      end
      ST_SCAN: begin
        advance    = !scan_emit || can_emit;
        ring.shift = advance;
        tail       = scan_ent;
        emit       = scan_emit && can_emit;
        emit_kind  = KIND_RELEASED;
        emit_tag   = head.tag;
        emit_last  = 1'b0;
      end
      ST_UPDATE: begin
        emit       = can_emit;
        emit_kind  = msg_kind;
        ring.wr_en = can_emit && (hit_found || free_found);
      end
      ST_DONE: begin
        emit      = can_emit;
        emit_kind = KIND_SCAN_DONE;
        emit_tag  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_tvalid      <= 1'b0;
      window_length <= 16'd10;
      rate_limit    <= 8'd5;
      idle_timeout  <= 16'd600;
      release_delay <= 16'd60;
    end else begin
      state <= state_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_idx)
          CFG_WINDOW_LENGTH: window_length <= cfg_data;
          CFG_RATE_LIMIT:    rate_limit    <= cfg_data[CNT_W-1:0];
          CFG_IDLE_TIMEOUT:  idle_timeout  <= cfg_data;
          CFG_RELEASE_DELAY: release_delay <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tuser <= emit_kind;
      m_tdata <= emit_tag;
      m_tlast <= emit_last;
    end
    if (accept) begin
      mode_r     <= s_tuser;
      tag_r      <= s_tdata[15:0];
      now_r      <= s_tdata[47:16];
      cnt        <= '0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (advance) begin
      cnt <= (cnt == LAST_IDX) ? '0 : cnt + IDX_W'(1);
      if (mode_r == MODE_MESSAGE) begin
        if (head.valid && head.tag == tag_r && !hit_found) begin
          hit_found <= 1'b1;
          hit_idx   <= cnt;
          hit_ent   <= head;
        end
        if (!head.valid && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= cnt;
        end
      end
    end
  end

endmodule

`default_nettype wire
